### rtl/brf_pkg.sv
// Shared types and constants for the byte ring FIFO with atomic puts.
// Used by byte_ring_fifo_atomic_put_top, brf_checker and tb; depends on nothing.
package brf_pkg;

	// Field widths of the word payloads
	localparam int KIND_W   = 2;
	localparam int BYTE_W   = 8;
	localparam int COUNT_W  = 10;
	localparam int STATUS_W = 2;
	localparam int TAKEN_W  = 7;
	localparam int CAP_W    = 9;
	localparam int REM_W    = 9;

	// Capacity register reset and put length saturation
	localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;
	localparam logic [REM_W-1:0] REM_MAX   = 9'd511;

	// Input word kinds
	localparam logic [KIND_W-1:0] KIND_PUT_START = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PUT_DATA  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_GET       = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_TOO_LONG = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NO_ROOM  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd3;

	// Control states
	typedef enum logic [0:0] {
		ST_IDLE,
		ST_GET
	} brf_state_t;

endpackage

### rtl/byte_ring_fifo_atomic_put_top.sv
// Byte ring FIFO with all-or-nothing message puts; top level.
// Depends on brf_pkg and brf_ram.
//
// A put start word announces a message length and gets one status word back
// (ok, too_long, no_room). Data bytes of an accepted put go into the store
// behind the committed data and become visible together with the last byte;
// bytes of a rejected put are dropped. A get word returns up to count bytes
// (at most MAX_GET), one output word per byte with last on the final one, or
// a single empty / zero-count word. A get that streams bytes stalls the input
// until its last byte is passed on: the bytes come from the single read port
// of the store RAM, one per cycle while the output is not stalled, behind its
// registered read. Writing the capacity register empties the fifo; write it
// only while the block is idle. The store needs no clearing after reset.
module byte_ring_fifo_atomic_put_top #(
	parameter int DEPTH   = 256,
	parameter int MAX_GET = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_wr_en,
	input  logic [brf_pkg::CAP_W-1:0]      cfg_wr_data,
	// input words
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [brf_pkg::KIND_W-1:0]     kind,
	input  logic [brf_pkg::BYTE_W-1:0]     data_byte,
	input  logic [brf_pkg::COUNT_W-1:0]    count,
	// result words
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [brf_pkg::STATUS_W-1:0]   status,
	output logic                           has_data,
	output logic [brf_pkg::BYTE_W-1:0]     read_byte,
	output logic                           last,
	output logic [brf_pkg::TAKEN_W-1:0]    taken
);

	localparam int AW = $clog2(DEPTH);
	localparam int VW = ((AW > brf_pkg::COUNT_W) ? AW : brf_pkg::COUNT_W) + 1;
	localparam int GW = brf_pkg::TAKEN_W;

	// Step a ring position, wrapping at the capacity in use
	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p,
						   input logic [VW-1:0] c);
		logic [VW-1:0] nx;
		nx = VW'(p) + VW'(1);
		return (nx == c) ? '0 : nx[AW-1:0];
	endfunction

	brf_pkg::brf_state_t state_q, state_nx;

	logic [brf_pkg::CAP_W-1:0] capacity_q;
	logic [AW-1:0]             write_pos_q;
	logic [AW-1:0]             read_pos_q;
	logic [AW-1:0]             pending_pos_q;
	logic                      is_full_q;
	logic [brf_pkg::REM_W-1:0] put_rem_q;
	logic                      put_acc_q;
	logic [GW-1:0]             iss_left_q;
	logic [GW-1:0]             out_left_q;
	logic [GW-1:0]             get_n_q;
	logic                      rd_valid_s1;

	logic                         out_valid_q;
	logic [brf_pkg::STATUS_W-1:0] status_q;
	logic                         has_data_q;
	logic [brf_pkg::BYTE_W-1:0]   read_byte_q;
	logic                         last_q;
	logic [GW-1:0]                taken_q;

	logic [VW-1:0] cap_w, wp_w, rp_w, used_w, left_w, count_w, n_w;
	logic [brf_pkg::COUNT_W-1:0] max_get_c, n_req;
	logic [GW-1:0]               get_n;
	logic [brf_pkg::STATUS_W-1:0] put_status;
	logic [AW-1:0]               pend_nx;
	logic                        in_acc, out_free, issue, consume;
	logic                        get_stream, load_item, put_wr;
	logic [brf_pkg::BYTE_W-1:0]  ram_rdata;

	// Capacity in use: zero acts as one, above DEPTH acts as DEPTH
	always_comb begin
		if (capacity_q == '0) begin
			cap_w = VW'(1);
		end else if (VW'(capacity_q) > VW'(DEPTH)) begin
			cap_w = VW'(DEPTH);
		end else begin
			cap_w = VW'(capacity_q);
		end
	end

	// Fill level and free space
	assign wp_w = VW'(write_pos_q);
	assign rp_w = VW'(read_pos_q);
	always_comb begin
		if (wp_w == rp_w) begin
			used_w = is_full_q ? cap_w : '0;
		end else if (wp_w > rp_w) begin
			used_w = wp_w - rp_w;
		end else begin
			used_w = wp_w + cap_w - rp_w;
		end
	end
	assign left_w  = cap_w - used_w;
	assign count_w = VW'(count);

	// Put start answer
	always_comb begin
		if (count_w > cap_w) begin
			put_status = brf_pkg::STAT_TOO_LONG;
		end else if (left_w < count_w) begin
			put_status = brf_pkg::STAT_NO_ROOM;
		end else begin
			put_status = brf_pkg::STAT_OK;
		end
	end

	// Bytes a get delivers: count capped at MAX_GET and at the fill level
	assign max_get_c = brf_pkg::COUNT_W'(MAX_GET);
	assign n_req     = (count > max_get_c) ? max_get_c : count;
	assign n_w       = (VW'(n_req) > used_w) ? used_w : VW'(n_req);
	assign get_n     = n_w[GW-1:0];

	assign pend_nx = wrap_inc(pending_pos_q, cap_w);

	// FSM outputs: handshake, read issue and output load
	always_comb begin
		out_free = !out_valid_q || !out_stall;
		in_stall = 1'b1;
		issue    = 1'b0;
		consume  = 1'b0;
		unique case (state_q)
			brf_pkg::ST_IDLE: begin
				in_stall = out_valid_q && out_stall;
			end
			brf_pkg::ST_GET: begin
				consume = rd_valid_s1 && out_free;
				issue   = (iss_left_q != '0) && (!rd_valid_s1 || out_free);
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	assign in_acc     = in_valid && !in_stall;
	assign get_stream = in_acc && (kind == brf_pkg::KIND_GET) && (count != '0)
			    && (used_w != '0);
	assign load_item  = in_acc && !get_stream && ((kind == brf_pkg::KIND_PUT_START)
			    || (kind == brf_pkg::KIND_GET));
	assign put_wr     = in_acc && (kind == brf_pkg::KIND_PUT_DATA)
			    && (put_rem_q != '0) && put_acc_q;

	// FSM next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			brf_pkg::ST_IDLE: begin
				if (get_stream) begin
					state_nx = brf_pkg::ST_GET;
				end
			end
			brf_pkg::ST_GET: begin
				if (consume && (out_left_q == GW'(1))) begin
					state_nx = brf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = brf_pkg::ST_IDLE;
			end
		endcase
	end

	// Byte store
	brf_ram #(
		.WIDTH(brf_pkg::BYTE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (put_wr),
		.waddr(pending_pos_q),
		.wdata(data_byte),
		.re   (issue),
		.raddr(read_pos_q),
		.rdata(ram_rdata)
	);

	// Fifo pointers, put tracking and get sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= brf_pkg::ST_IDLE;
			capacity_q    <= brf_pkg::CAP_RESET;
			write_pos_q   <= '0;
			read_pos_q    <= '0;
			pending_pos_q <= '0;
			is_full_q     <= 1'b0;
			put_rem_q     <= '0;
			put_acc_q     <= 1'b0;
			iss_left_q    <= '0;
			out_left_q    <= '0;
			get_n_q       <= '0;
			rd_valid_s1   <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q     <= state_nx;
			rd_valid_s1 <= issue || (rd_valid_s1 && !consume);

			if (load_item || consume) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (in_acc) begin
				unique case (kind)
					brf_pkg::KIND_PUT_START: begin
						put_acc_q     <= (put_status == brf_pkg::STAT_OK)
								 && (count != '0);
						pending_pos_q <= write_pos_q;
						if (count == '0) begin
							put_rem_q <= '0;
						end else if (count > brf_pkg::COUNT_W'(brf_pkg::REM_MAX)) begin
							put_rem_q <= brf_pkg::REM_MAX;
						end else begin
							put_rem_q <= count[brf_pkg::REM_W-1:0];
						end
					end
					brf_pkg::KIND_PUT_DATA: begin
						if (put_rem_q != '0) begin
							put_rem_q <= put_rem_q - brf_pkg::REM_W'(1);
							if (put_acc_q) begin
								pending_pos_q <= pend_nx;
							end
							// last byte of an accepted put commits the message
							if (put_acc_q && (put_rem_q == brf_pkg::REM_W'(1))) begin
								write_pos_q <= pend_nx;
								is_full_q   <= (pend_nx == read_pos_q);
								put_acc_q   <= 1'b0;
							end
						end
					end
					brf_pkg::KIND_GET: begin
						if (get_stream) begin
							is_full_q  <= 1'b0;
							iss_left_q <= get_n;
							out_left_q <= get_n;
							get_n_q    <= get_n;
						end
					end
					default: begin
					end
				endcase
			end

			// streaming reads of a get
			if (issue) begin
				read_pos_q <= wrap_inc(read_pos_q, cap_w);
				iss_left_q <= iss_left_q - GW'(1);
			end
			if (consume) begin
				out_left_q <= out_left_q - GW'(1);
			end

			// capacity write empties the fifo
			if (cfg_wr_en) begin
				capacity_q    <= cfg_wr_data;
				write_pos_q   <= '0;
				read_pos_q    <= '0;
				pending_pos_q <= '0;
				is_full_q     <= 1'b0;
				put_rem_q     <= '0;
				put_acc_q     <= 1'b0;
			end
		end
	end

	// Output word register
	always_ff @(posedge clk) begin
		if (consume) begin
			status_q    <= brf_pkg::STAT_OK;
			has_data_q  <= 1'b1;
			read_byte_q <= ram_rdata;
			last_q      <= (out_left_q == GW'(1));
			taken_q     <= get_n_q;
		end else if (load_item) begin
			if (kind == brf_pkg::KIND_PUT_START) begin
				status_q <= put_status;
			end else if (count == '0) begin
				status_q <= brf_pkg::STAT_OK;
			end else begin
				status_q <= brf_pkg::STAT_EMPTY;
			end
			has_data_q  <= 1'b0;
			read_byte_q <= '0;
			last_q      <= 1'b1;
			taken_q     <= '0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign has_data  = has_data_q;
	assign read_byte = read_byte_q;
	assign last      = last_q;
	assign taken     = taken_q;

endmodule

### rtl/brf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; the read data holds while the read enable is low.
module brf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sim/brf_checker.sv
// Scoreboard for byte_ring_fifo_atomic_put_top: follows the capacity port and both
// word channels, predicts every result word and compares them in arrival order.
// Depends on brf_pkg.
module brf_checker #(
	parameter int DEPTH   = 256,
	parameter int MAX_GET = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [brf_pkg::CAP_W-1:0]      cfg_wr_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [brf_pkg::KIND_W-1:0]     kind,
	input  logic [brf_pkg::BYTE_W-1:0]     data_byte,
	input  logic [brf_pkg::COUNT_W-1:0]    count,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [brf_pkg::STATUS_W-1:0]   status,
	input  logic                           has_data,
	input  logic [brf_pkg::BYTE_W-1:0]     read_byte,
	input  logic                           last,
	input  logic [brf_pkg::TAKEN_W-1:0]    taken,
	output int                             mismatches,
	output int                             outstanding,
	output int                             checked_words,
	output int                             room,
	output int                             cap_now
);
	timeunit 1ns;
	timeprecision 1ps;
	import brf_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                has_data;
		logic [BYTE_W-1:0]   read_byte;
		logic                last;
		logic [TAKEN_W-1:0]  taken;
	} fifo_result_t;

	// Result words still owed by the block, oldest first
	fifo_result_t due_results[$];

	// Shadow copy of the fifo
	logic [BYTE_W-1:0] ring [DEPTH];
	logic [CAP_W-1:0]  cap_reg;
	logic [PTR_W-1:0]  wr_ptr, rd_ptr, pend_ptr;
	logic              full_flag, put_open;
	logic [REM_W-1:0]  put_left;
	int                bad, seen;

	// Capacity as the block applies it: 0 acts as 1, above DEPTH acts as DEPTH
	function automatic int eff_capacity();
		int c;
		c = int'(cap_reg);
		if (c < 1) c = 1;
		if (c > DEPTH) c = DEPTH;
		return c;
	endfunction

	// Committed bytes in the ring
	function automatic int bytes_held(int cap);
		if (wr_ptr == rd_ptr) return full_flag ? cap : 0;
		return (int'(wr_ptr) + cap - int'(rd_ptr)) % cap;
	endfunction

	task automatic empty_ring();
		wr_ptr    = '0;
		rd_ptr    = '0;
		pend_ptr  = '0;
		full_flag = 1'b0;
		put_open  = 1'b0;
		put_left  = '0;
	endtask

	// Advance the shadow fifo by one input word and queue the words it causes
	task automatic apply_word(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] b,
			input logic [COUNT_W-1:0] n);
		int cap, held, want, p, i;
		fifo_result_t r;
		cap  = eff_capacity();
		held = bytes_held(cap);
		r    = '0;
		r.last = 1'b1;
		case (k)
		KIND_PUT_START: begin
			// a new start abandons any unfinished put
			put_open = 1'b0;
			put_left = '0;
			if (n > cap) begin
				r.status = STAT_TOO_LONG;
			end else if (cap - held < n) begin
				r.status = STAT_NO_ROOM;
			end else begin
				r.status = STAT_OK;
				if (n != 0) begin
					put_open = 1'b1;
					pend_ptr = (wr_ptr < cap) ? wr_ptr : '0;
				end
			end
			// rejected puts still swallow their data bytes, up to the saturation
			if (n != 0) put_left = (n > REM_MAX) ? REM_MAX : n[REM_W-1:0];
			due_results.push_back(r);
		end
		KIND_PUT_DATA: begin
			if (put_left != 0) begin
				if (put_open) begin
					p = (pend_ptr < cap) ? int'(pend_ptr) : 0;
					ring[p]  = b;
					pend_ptr = PTR_W'((p + 1) % cap);
				end
				put_left = put_left - 1'b1;
				// last byte makes the whole message visible
				if (put_left == 0 && put_open) begin
					wr_ptr = pend_ptr;
					if (wr_ptr == rd_ptr) full_flag = 1'b1;
					put_open = 1'b0;
				end
			end
		end
		KIND_GET: begin
			if (n == 0) begin
				r.status = STAT_OK;
				due_results.push_back(r);
			end else if (held == 0) begin
				r.status = STAT_EMPTY;
				due_results.push_back(r);
			end else begin
				want = (n > MAX_GET) ? MAX_GET : int'(n);
				if (want > held) want = held;
				p = (rd_ptr < cap) ? int'(rd_ptr) : 0;
				for (i = 0; i < want; i++) begin
					r.status    = STAT_OK;
					r.has_data  = 1'b1;
					r.read_byte = ring[p];
					r.last      = (i + 1 == want);
					r.taken     = TAKEN_W'(want);
					due_results.push_back(r);
					p = (p + 1) % cap;
				end
				rd_ptr    = PTR_W'(p);
				full_flag = 1'b0;
			end
		end
		default: ;  // unused kind: no effect
		endcase
	endtask

	// Compare one accepted result word with the oldest prediction
	task automatic check_word(input fifo_result_t got);
		fifo_result_t want;
		seen++;
		if (due_results.size() == 0) begin
			bad++;
			if (bad <= 10)
				$display("unexpected result word: status=%0d has_data=%0d read_byte=%02h last=%0d taken=%0d",
					got.status, got.has_data, got.read_byte, got.last, got.taken);
		end else begin
			want = due_results.pop_front();
			if (got !== want) begin
				bad++;
				if (bad <= 10) begin
					$display("result word %0d: expected status=%0d has_data=%0d read_byte=%02h last=%0d taken=%0d",
						seen, want.status, want.has_data, want.read_byte, want.last, want.taken);
					$display("result word %0d:      got status=%0d has_data=%0d read_byte=%02h last=%0d taken=%0d",
						seen, got.status, got.has_data, got.read_byte, got.last, got.taken);
				end
			end
		end
	endtask

	// Watch both channels at the rising edge; inputs first so a same-cycle answer lines up
	always @(posedge clk or negedge arst_n) begin : watch
		fifo_result_t got;
		if (!arst_n) begin
			cap_reg = CAP_RESET;
			empty_ring();
			due_results.delete();
			bad  = 0;
			seen = 0;
		end else begin
			if (cfg_wr_en) begin
				cap_reg = cfg_wr_data;
				empty_ring();
			end
			if (in_valid && !in_stall) apply_word(kind, data_byte, count);
			if (out_valid && !out_stall) begin
				got.status    = status;
				got.has_data  = has_data;
				got.read_byte = read_byte;
				got.last      = last;
				got.taken     = taken;
				check_word(got);
			end
		end
		mismatches    <= bad;
		outstanding   <= due_results.size();
		checked_words <= seen;
		cap_now       <= eff_capacity();
		room          <= eff_capacity() - bytes_held(eff_capacity());
	end

endmodule

### sim/tb.sv
// Top of the byte ring fifo testbench: clock, reset, capacity writes and word
// stimulus with random gaps and output stalls; brf_checker does the checking.
// Depends on brf_pkg, brf_checker and byte_ring_fifo_atomic_put_top.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import brf_pkg::*;

	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;  // unused kind, block ignores it
	localparam int LIMIT_CYCLES  = 1_500_000;
	localparam int SETTLE        = 8;
	localparam int PHASE_WORDS   = 17;
	localparam int FILL_CAP_MAX  = 8;   // capacities below this get filled to the brim

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [CAP_W-1:0]    cfg_wr_data;
	logic                in_valid, in_stall;
	logic [KIND_W-1:0]   kind;
	logic [BYTE_W-1:0]   data_byte;
	logic [COUNT_W-1:0]  count;
	logic                out_valid, out_stall;
	logic [STATUS_W-1:0] status;
	logic                has_data;
	logic [BYTE_W-1:0]   read_byte;
	logic                last;
	logic [TAKEN_W-1:0]  taken;

	int mismatches, outstanding, checked_words, room, cap_now;
	int cycles = 0;
	int words_sent = 0;
	int burst_left = 0;

	// Capacity settings after the directed part, extremes included
	int caps[8] = '{1, 0, 7, 511, 40, 300, 2, 256};

	always #1 clk = ~clk;
	always @(posedge clk) cycles <= cycles + 1;

	byte_ring_fifo_atomic_put_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .data_byte(data_byte), .count(count),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .has_data(has_data), .read_byte(read_byte),
		.last(last), .taken(taken)
	);

	brf_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .data_byte(data_byte), .count(count),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .has_data(has_data), .read_byte(read_byte),
		.last(last), .taken(taken),
		.mismatches(mismatches), .outstanding(outstanding),
		.checked_words(checked_words), .room(room), .cap_now(cap_now)
	);

	// Sender gap: mostly none, some short, a few long, with occasional gapless bursts
	function automatic int next_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst_left = $urandom_range(10, 30);
			return 0;
		end
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	// Present one input word after a random gap and hold it until accepted
	task automatic send_word(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] b,
			input logic [COUNT_W-1:0] n);
		int gap;
		gap = next_gap();
		repeat (gap) begin
			@(negedge clk);
			in_valid  <= 1'b0;
			kind      <= KIND_W'($urandom_range(0, 3));
			data_byte <= BYTE_W'($urandom_range(0, 255));
			count     <= COUNT_W'($urandom_range(0, 1023));
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		kind      <= k;
		data_byte <= b;
		count     <= n;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	// Put start of length len followed by nb data bytes
	task automatic send_put(input int len, input int nb);
		send_word(KIND_PUT_START, BYTE_W'($urandom_range(0, 255)), COUNT_W'(len));
		repeat (nb) send_word(KIND_PUT_DATA, BYTE_W'($urandom_range(0, 255)),
				COUNT_W'($urandom_range(0, 1023)));
	endtask

	// Stop sending until every predicted word is back and the block has gone quiet
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		settle();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Random traffic: mostly complete puts and gets, the rest rejected,
	// broken or stray words
	task automatic run_phase(input int budget);
		int done, r, q, c, len, nb;
		done = 0;
		while (done < budget) begin
			c = cap_now;
			r = $urandom_range(0, 99);
			if (r < 38) begin
				// well-formed put, room sampled once the last word has settled
				@(negedge clk);
				in_valid <= 1'b0;
				q = $urandom_range(0, 9);
				if (q < 7) len = $urandom_range(1, (c < 6) ? c : 6);
				else if (room <= 48) len = room;
				else len = $urandom_range(1, 48);
				send_put(len, len);
				done += 1 + len;
			end else if (r < 66) begin
				q = $urandom_range(0, 9);
				if (q == 0) len = 0;
				else if (q < 8) len = $urandom_range(1, 70);
				else len = $urandom_range(71, 1023);
				send_word(KIND_GET, BYTE_W'($urandom_range(0, 255)), COUNT_W'(len));
				done++;
			end else if (r < 76) begin
				// rejected put: too long, or more than the free space
				@(negedge clk);
				in_valid <= 1'b0;
				if ($urandom_range(0, 1) == 0 || room == c)
					len = $urandom_range(c + 1, 1023);
				else
					len = $urandom_range(room + 1, c);
				nb = $urandom_range(0, 4);
				send_put(len, nb);
				done += 1 + nb;
			end else if (r < 84) begin
				// put cut short, the next start abandons it
				len = $urandom_range(1, (c < 8) ? c : 8);
				nb  = $urandom_range(0, len - 1);
				send_put(len, nb);
				done += 1 + nb;
			end else if (r < 88) begin
				send_put(0, 0);
				done++;
			end else if (r < 92) begin
				send_word(KIND_PUT_DATA, BYTE_W'($urandom_range(0, 255)),
					COUNT_W'($urandom_range(0, 1023)));
			end else if (r < 96) begin
				send_word(KIND_NONE, BYTE_W'($urandom_range(0, 255)),
					COUNT_W'($urandom_range(0, 1023)));
			end else if (r < 99) begin
				send_word(KIND_GET, BYTE_W'($urandom_range(0, 255)),
					COUNT_W'($urandom_range(64, 1023)));
				done++;
			end else begin
				settle();
			end
		end
	endtask

	// Output stalls: runs of acceptance broken by stalls, mostly short
	initial begin
		int run, hold, r;
		out_stall = 1'b0;
		forever begin
			r = $urandom_range(0, 99);
			run = (r < 10) ? $urandom_range(40, 120) : $urandom_range(1, 24);
			r = $urandom_range(0, 99);
			if (r < 70) hold = $urandom_range(1, 3);
			else if (r < 93) hold = $urandom_range(4, 8);
			else hold = $urandom_range(10, 20);
			repeat (run) begin
				@(negedge clk);
				out_stall <= 1'b0;
			end
			repeat (hold) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
		end
	end

	initial begin
		wait (cycles >= LIMIT_CYCLES);
		$display("tb failed");
		$finish;
	end

	// Main stimulus
	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		kind        = KIND_PUT_START;
		data_byte   = '0;
		count       = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed words at the reset capacity
		send_word(KIND_GET, 8'h00, 10'd5);         // get on empty fifo
		send_word(KIND_GET, 8'hFF, 10'd0);         // zero-count get
		send_word(KIND_PUT_DATA, 8'hFF, 10'd0);    // data with no put open
		send_word(KIND_NONE, 8'hFF, 10'h3FF);      // unused kind
		send_word(KIND_PUT_START, 8'h00, 10'd0);   // zero-length put
		send_word(KIND_PUT_START, 8'h00, 10'd257); // longer than capacity
		send_word(KIND_PUT_DATA, 8'h00, 10'd0);    // dropped
		send_word(KIND_PUT_START, 8'h00, 10'd3);
		send_word(KIND_PUT_DATA, 8'h00, 10'h3FF);
		send_word(KIND_PUT_DATA, 8'hFF, 10'd0);
		send_word(KIND_PUT_DATA, 8'hA5, 10'd0);
		send_word(KIND_GET, 8'h00, 10'h3FF);       // capped by MAX_GET and by fill
		send_word(KIND_PUT_START, 8'h00, 10'd2);
		send_word(KIND_PUT_DATA, 8'h11, 10'd0);
		send_word(KIND_PUT_START, 8'h00, 10'd1);   // abandons the open put
		send_word(KIND_PUT_DATA, 8'h5A, 10'd0);
		send_word(KIND_GET, 8'h00, 10'd64);
		send_word(KIND_PUT_START, 8'h00, 10'h3FF); // too long, length saturates
		send_word(KIND_PUT_DATA, 8'h33, 10'd0);
		send_word(KIND_GET, 8'h00, 10'd2);         // empty again

		// Over-long put: its bytes are dropped, a fresh start afterwards still works
		send_put(1000, 3);
		send_put(1, 1);
		send_word(KIND_GET, 8'h00, 10'd1);

		foreach (caps[i]) begin
			write_capacity(CAP_W'(caps[i]));
			if (caps[i] < FILL_CAP_MAX) begin
				// fill the whole store once, then ask for one more byte
				send_put(room, room);
				send_word(KIND_PUT_START, 8'h00, 10'd1);
			end
			run_phase(PHASE_WORDS);
		end

		settle();
		$display("%0d input words over %0d capacity settings, %0d result words compared",
			words_sent, $size(caps) + 1, checked_words);
		if (mismatches == 0 && outstanding == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
